// ===== hdl/ngs_pkg.sv =====
package ngs_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int POS_W = 16;
	localparam int VALUE_W = 32;
	localparam int IN_W = (VALUE_W < 32) ? VALUE_W : 32;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int OUT_POS_W = 16;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic signed [VALUE_W-1:0] val_t;

	// one stack entry as held in a cell
	typedef struct packed {
		pos_t pos;
		val_t val;
	} entry_t;

	// shift command broadcast along the chain
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH,
		OP_POP
	} op_t;

	// sign extend the input sample to the internal value width
	function automatic val_t ext_value(logic [31:0] v);
		val_t r;
		for (int i = 0; i < VALUE_W; i++) begin
			r[i] = (i < IN_W) ? v[i] : v[IN_W-1];
		end
		return r;
	endfunction

	// fit a position into the output field width
	function automatic logic [OUT_POS_W-1:0] out_pos(pos_t p);
		logic [OUT_POS_W-1:0] r;
		for (int i = 0; i < OUT_POS_W; i++) begin
			r[i] = (i < POS_W) ? p[(i < POS_W) ? i : 0] : 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== hdl/ngs_cell.sv =====
module ngs_cell (
	input  logic           clk,
	input  ngs_pkg::op_t   op,
	input  ngs_pkg::val_t  key,
	input  ngs_pkg::entry_t from_above,
	input  ngs_pkg::entry_t from_below,
	output ngs_pkg::entry_t entry,
	output logic           le
);
	import ngs_pkg::*;

	entry_t entry_q;

	// shift toward the bottom on push, toward the top on pop
	always_ff @(posedge clk) begin
		case (op)
			OP_PUSH: entry_q <= from_above;
			OP_POP:  entry_q <= from_below;
			default: entry_q <= entry_q;
		endcase
	end

	// this entry is resolved by the current sample
	assign le = (entry_q.val <= key);
	assign entry = entry_q;

endmodule

// ===== hdl/next_greater_or_equal_stack.sv =====
// channel  direction  handshake             payload
// input    in         in_valid / in_stall   value, end_of_sequence
// output   out        out_valid / out_stall waiting_position, next_position,
//                                           dropped_any, last_of_run
//
// an item is handled in steps: one to load the sample, one pop per entry it
// resolves, and one push of the sample through the cell chain.
// pops go one entry per cycle while the output is free; cell 0 is the top.
// reset clears the count, position counter, overflow flag and handshake state;
// the cells themselves are not reset.
// a stalled output holds the pending pop; in_stall is high while an item is at work.
module next_greater_or_equal_stack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [31:0]             value,
	input  logic                           end_of_sequence,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ngs_pkg::OUT_POS_W-1:0]  waiting_position,
	output logic [ngs_pkg::OUT_POS_W-1:0]  next_position,
	output logic                           dropped_any,
	output logic                           last_of_run
);
	import ngs_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_WORK
	} state_t;

	state_t             state_q;
	val_t               v_q;
	logic               eos_q;
	pos_t               pos_q;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;

	op_t                op;
	entry_t             new_entry;
	entry_t             ent [STACK_DEPTH];
	logic               le [STACK_DEPTH];
	logic               out_free;
	logic               pop_ok;
	logic               full;

	// chain of cells, top at index 0
	assign new_entry = '{pos: pos_q, val: v_q};

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		entry_t above;
		entry_t below;
		if (i == 0) begin : g_top
			assign above = new_entry;
		end else begin : g_mid
			assign above = ent[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign below = '0;
		end else begin : g_up
			assign below = ent[i+1];
		end
		ngs_cell u_cell (
			.clk        (clk),
			.op         (op),
			.key        (v_q),
			.from_above (above),
			.from_below (below),
			.entry      (ent[i]),
			.le         (le[i])
		);
	end

	// pop while the top is resolved and the output is free, else push and finish
	assign out_free = !out_valid || !out_stall;
	assign pop_ok = (count_q != '0) && le[0];
	assign full = (count_q == CNT_W'(STACK_DEPTH));
	assign in_stall = (state_q == S_WORK);

	always_comb begin
		op = OP_HOLD;
		if (state_q == S_WORK) begin
			if (pop_ok) begin
				if (out_free) begin
					op = OP_POP;
				end
			end else begin
				op = OP_PUSH;
			end
		end
	end

	// control state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pos_q <= '0;
			ovf_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			// load on a pop, clear once the transfer is taken
			out_valid <= (op == OP_POP) || (out_valid && out_stall);
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						v_q <= ext_value(value);
						eos_q <= end_of_sequence;
						state_q <= S_WORK;
					end
				end
				S_WORK: begin
					if (op == OP_POP) begin
						waiting_position <= out_pos(ent[0].pos);
						next_position <= out_pos(pos_q);
						dropped_any <= ovf_q;
						last_of_run <= (count_q == CNT_W'(1)) || !le[1];
						count_q <= count_q - CNT_W'(1);
					end else if (op == OP_PUSH) begin
						state_q <= S_IDLE;
						if (eos_q) begin
							count_q <= '0;
							pos_q <= '0;
							ovf_q <= 1'b0;
						end else begin
							pos_q <= pos_q + POS_W'(1);
							if (full) begin
								ovf_q <= 1'b1;
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// stack never holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
	else $error("stack count beyond depth");

	// a pop always produces a pending transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_POP) |=> out_valid)
	else $error("pop without output");

	// end of sequence empties the stack
	assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_PUSH && eos_q) |=> (count_q == '0 && pos_q == '0 && !ovf_q))
	else $error("end of sequence did not clear");

	// no pop is taken while the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> (op != OP_POP))
	else $error("pop over a stalled output");
`endif

endmodule
